>>> hdl/bba_pkg.sv
package bba_pkg;

  localparam int IndexW = 12;

  localparam logic CMD_FIND = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_BLOCK = 1'b1;

  typedef enum logic [1:0] {
    RC_OK    = 2'd0,
    RC_RANGE = 2'd1,
    RC_FULL  = 2'd2
  } code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_SET_CHECK,
    ST_SET_SPLIT,
    ST_SET_READ,
    ST_SET_WRITE
  } state_t;

  typedef struct packed {
    logic              command;
    logic              map_select;
    logic [IndexW-1:0] entry_index;
    logic              mark_used;
  } req_t;

  typedef struct packed {
    logic [IndexW-1:0] found_index;
    logic [1:0]        result_code;
  } rsp_t;

endpackage

>>> hdl/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bitmap_block_allocator_core.sv
// First-fit allocator over two bitmaps (inodes and data blocks), one bit per
// entry, 1 = used. Each bitmap lives in a word-wide RAM with a registered read.
// A find reads one bitmap word per cycle from word 0 and stops at the first
// word with a free bit, or after the last word when the map is full. A set
// steps through range check, index split, read and write back; an index out
// of range answers from the range check. One request is in flight at a time
// and busy is high until its result has been strobed on done; a new request
// may be taken in the cycle that done is high. After reset the block sweeps
// both RAMs to zero with busy held high, one word a cycle through
// max(INODE_ENTRIES, BLOCK_ENTRIES) / WORD_BITS words (rounded up). The result
// is valid for the single cycle that done is high and must be taken then.
module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int INODE_ENTRIES = 1024,
  parameter int BLOCK_ENTRIES = 4096,
  parameter int WORD_BITS     = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int InodeWords = (INODE_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int BlockWords = (BLOCK_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int MaxWords   = (InodeWords > BlockWords) ? InodeWords : BlockWords;
  localparam int MaxEntries = (INODE_ENTRIES > BLOCK_ENTRIES) ? INODE_ENTRIES
                                                              : BLOCK_ENTRIES;
  localparam int AW  = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int IAW = (InodeWords > 1) ? $clog2(InodeWords) : 1;
  localparam int BAW = (BlockWords > 1) ? $clog2(BlockWords) : 1;
  localparam int BW  = $clog2(WORD_BITS);
  localparam int EW  = $clog2(MaxEntries + WORD_BITS) + 1;
  localparam int CW  = 18;

  localparam int InodeLastBits = INODE_ENTRIES - (InodeWords - 1) * WORD_BITS;
  localparam int BlockLastBits = BLOCK_ENTRIES - (BlockWords - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] InodePad =
    ~({WORD_BITS{1'b1}} >> (WORD_BITS - InodeLastBits));
  localparam logic [WORD_BITS-1:0] BlockPad =
    ~({WORD_BITS{1'b1}} >> (WORD_BITS - BlockLastBits));

  localparam logic [AW:0] InodeLast = (AW + 1)'(InodeWords - 1);
  localparam logic [AW:0] BlockLast = (AW + 1)'(BlockWords - 1);
  localparam logic [AW:0] ClearLast = (AW + 1)'(MaxWords - 1);
  localparam logic [AW:0] InodeCnt  = (AW + 1)'(InodeWords);
  localparam logic [AW:0] BlockCnt  = (AW + 1)'(BlockWords);
  localparam logic [CW-1:0] InodeEnt = CW'(INODE_ENTRIES);
  localparam logic [CW-1:0] BlockEnt = CW'(BLOCK_ENTRIES);

  // Reciprocal for the entry index split: exact floor for 12-bit indexes.
  localparam int RecipShift = IndexW + BW;
  localparam int Recip = (2 ** RecipShift + WORD_BITS - 1) / WORD_BITS;
  localparam int QW = IndexW;

  state_t state, state_next;

  logic              sel;
  logic [IndexW-1:0] idx;
  logic              used;

  logic [AW:0]      clr_addr;
  logic [AW:0]      rd_addr;
  logic [EW-1:0]    base_rd;
  logic [EW-1:0]    chk_base;
  logic             chk_valid;
  logic             chk_last;
  logic [QW-1:0]    word_q;
  logic [BW-1:0]    bit_pos;

  logic             i_we, b_we;
  logic [AW-1:0]    waddr, raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] i_rdata, b_rdata, rdata;

  logic [AW:0]          last_word;
  logic [WORD_BITS-1:0] pad_sel;
  logic [CW-1:0]        ent_sel;
  logic                 in_range;
  logic                 issue;
  logic [WORD_BITS-1:0] free_bits;
  logic                 hit;
  logic [BW-1:0]        hit_pos;
  logic [31:0]          prod;
  logic [QW-1:0]        q_est;
  logic [IndexW+1:0]    rem_raw;
  logic [WORD_BITS-1:0] bit_mask;

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(InodeWords)) u_inode_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (waddr[IAW-1:0]),
    .wdata (wdata),
    .raddr (raddr[IAW-1:0]),
    .rdata (i_rdata)
  );

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(BlockWords)) u_block_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr[BAW-1:0]),
    .wdata (wdata),
    .raddr (raddr[BAW-1:0]),
    .rdata (b_rdata)
  );

  assign rdata     = (sel == MAP_BLOCK) ? b_rdata : i_rdata;
  assign last_word = (sel == MAP_BLOCK) ? BlockLast : InodeLast;
  assign pad_sel   = (sel == MAP_BLOCK) ? BlockPad : InodePad;
  assign ent_sel   = (sel == MAP_BLOCK) ? BlockEnt : InodeEnt;
  assign in_range  = CW'(idx) < ent_sel;
  assign issue     = rd_addr <= last_word;
  assign busy      = state != ST_IDLE;

  // Padding above the last entry counts as used so it is never found.
  assign free_bits = ~(rdata | (chk_last ? pad_sel : '0));
  assign hit       = chk_valid && (|free_bits);

  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_pos = BW'(i);
      end
    end
  end

  assign prod     = 32'(idx) * 32'(Recip);
  assign q_est    = QW'(prod >> RecipShift);
  assign rem_raw  = (IndexW + 2)'(idx) - (IndexW + 2)'(32'(word_q) * 32'(WORD_BITS));
  assign bit_mask = WORD_BITS'(1) << bit_pos;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ClearLast) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (request.command == CMD_FIND) ? ST_FIND : ST_SET_CHECK;
        end
      end
      ST_FIND: begin
        if (hit || (chk_valid && chk_last)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SET_CHECK: state_next = in_range ? ST_SET_SPLIT : ST_IDLE;
      ST_SET_SPLIT: state_next = ST_SET_READ;
      ST_SET_READ:  state_next = ST_SET_WRITE;
      ST_SET_WRITE: state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    i_we  = 1'b0;
    b_we  = 1'b0;
    waddr = rd_addr[AW-1:0];
    raddr = rd_addr[AW-1:0];
    wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        i_we  = clr_addr < InodeCnt;
        b_we  = clr_addr < BlockCnt;
        waddr = clr_addr[AW-1:0];
      end
      ST_SET_WRITE: begin
        i_we  = sel == MAP_INODE;
        b_we  = sel == MAP_BLOCK;
        wdata = used ? (rdata | bit_mask) : (rdata & ~bit_mask);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_FIND && (hit || (chk_valid && chk_last))) begin
        done <= 1'b1;
      end
      if (state == ST_SET_CHECK && !in_range) begin
        done <= 1'b1;
      end
      if (state == ST_SET_WRITE) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sel       <= request.map_select;
        idx       <= request.entry_index;
        used      <= request.mark_used;
        rd_addr   <= '0;
        base_rd   <= '0;
        chk_valid <= 1'b0;
        chk_last  <= 1'b0;
      end
      ST_FIND: begin
        // Read one word a cycle; check the word read in the cycle before.
        chk_valid <= issue;
        chk_last  <= rd_addr == last_word;
        chk_base  <= base_rd;
        if (issue) begin
          rd_addr <= rd_addr + 1'b1;
          base_rd <= base_rd + EW'(WORD_BITS);
        end
        if (hit) begin
          result.found_index <= IndexW'(chk_base + EW'(hit_pos));
          result.result_code <= RC_OK;
        end else if (chk_valid && chk_last) begin
          result.found_index <= '0;
          result.result_code <= RC_FULL;
        end
      end
      ST_SET_CHECK: begin
        word_q <= q_est;
        if (!in_range) begin
          result.found_index <= '0;
          result.result_code <= RC_RANGE;
        end
      end
      ST_SET_SPLIT: begin
        if (rem_raw >= (IndexW + 2)'(WORD_BITS)) begin
          rd_addr <= (AW + 1)'(word_q + 1'b1);
          bit_pos <= BW'(rem_raw - (IndexW + 2)'(WORD_BITS));
        end else begin
          rd_addr <= (AW + 1)'(word_q);
          bit_pos <= BW'(rem_raw);
        end
      end
      ST_SET_WRITE: begin
        result.found_index <= '0;
        result.result_code <= RC_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> verif/bitmap_block_allocator_core_tb.sv
module bitmap_block_allocator_core_tb
  import bba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int INODE_N   = 1024;
  localparam int BLOCK_N   = 4096;
  localparam int WORD_W    = 32;
  localparam int QUIET_MAX = 2000;
  localparam int DIR_ROWS  = 23;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  bit   inode_used [INODE_N];
  bit   block_used [BLOCK_N];
  rsp_t pending_rsp [$];
  int   fails = 0;
  int   sent = 0;
  int   quiet = 0;
  bit   idle_on = 1'b0;
  bit   start_lowered = 1'b0;
  row_t plan [DIR_ROWS];

  bitmap_block_allocator_core #(
    .INODE_ENTRIES(INODE_N),
    .BLOCK_ENTRIES(BLOCK_N),
    .WORD_BITS    (WORD_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #4 clk = ~clk;

  // First-fit search over the shadow bitmaps; -1 when the map is full.
  function automatic int lowest_free(input logic m);
    int n;
    n = (m == MAP_BLOCK) ? BLOCK_N : INODE_N;
    for (int e = 0; e < n; e++) begin
      if ((m == MAP_BLOCK) ? !block_used[e] : !inode_used[e]) return e;
    end
    return -1;
  endfunction

  function automatic rsp_t allocate_step(input req_t r);
    rsp_t o;
    int   n;
    int   hit;
    o = '0;
    n = (r.map_select == MAP_BLOCK) ? BLOCK_N : INODE_N;
    if (r.command == CMD_FIND) begin
      hit = lowest_free(r.map_select);
      if (hit < 0) o.result_code = RC_FULL;
      else o.found_index = hit[IndexW-1:0];
    end else if (int'(r.entry_index) >= n) begin
      o.result_code = RC_RANGE;
    end else if (r.map_select == MAP_BLOCK) begin
      block_used[r.entry_index] = r.mark_used;
    end else begin
      inode_used[r.entry_index] = r.mark_used;
    end
    return o;
  endfunction

  // Hold the request until accepted, then update the shadow maps.
  task automatic send(input req_t r, input bit typed = 1'b0, input rsp_t typed_rsp = '0);
    rsp_t predicted;
    request <= r;
    if (start_lowered) start <= 1'b1;
    start_lowered = 1'b0;
    do @(posedge clk); while (busy);
    predicted = allocate_step(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    sent++;
    if (idle_on && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
      start_lowered = 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic find_req(input logic m);
    req_t r;
    r.command     = CMD_FIND;
    r.map_select  = m;
    r.entry_index = IndexW'($urandom);
    r.mark_used   = 1'($urandom);
    send(r);
  endtask

  task automatic set_req(input logic m, input int idx, input logic used);
    req_t r;
    r.command     = CMD_SET;
    r.map_select  = m;
    r.entry_index = idx[IndexW-1:0];
    r.mark_used   = used;
    send(r);
  endtask

  task automatic mix(input int upto);
    int   kind;
    int   n;
    int   h;
    logic m;
    logic [$bits(req_t)-1:0] raw;
    while (sent < upto) begin
      kind = $urandom_range(0, 99);
      m    = 1'($urandom_range(0, 1));
      n    = (m == MAP_BLOCK) ? BLOCK_N : INODE_N;
      if (kind < 40) begin
        // allocator pattern: find, then claim what was found
        repeat ($urandom_range(1, 24)) begin
          find_req(m);
          h = lowest_free(m);
          if (h >= 0) set_req(m, h, 1'b1);
        end
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 10))
          set_req(m, $urandom_range(0, (n - 1) >> $urandom_range(0, 6)), 1'b0);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 8)) begin
          raw = ($bits(req_t))'($urandom);
          send(raw);
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6))
          set_req(MAP_INODE, $urandom_range(INODE_N, (1 << IndexW) - 1), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) find_req(m);
      end
    end
  endtask

  // Claim every entry, then punch single holes anywhere, the last entry included.
  task automatic fill_map(input logic m);
    int n;
    int h;
    int k;
    n = (m == MAP_BLOCK) ? BLOCK_N : INODE_N;
    k = 0;
    h = lowest_free(m);
    while (h >= 0) begin
      set_req(m, h, 1'b1);
      k++;
      if (k % 32 == 0) find_req(m);
      h = lowest_free(m);
    end
    repeat (3) find_req(m);
    repeat (16) begin
      h = $urandom_range(0, n - 1);
      set_req(m, h, 1'b0);
      find_req(m);
      set_req(m, h, 1'b1);
    end
    set_req(m, n - 1, 1'b0);
    find_req(m);
    set_req(m, n - 1, 1'b1);
    find_req(m);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding: found_index %0d result_code %0d",
               result.found_index, result.result_code);
        fails++;
      end else begin
        if (result.found_index !== pending_rsp[0].found_index) begin
          $error("found_index: expected %0d, got %0d",
                 pending_rsp[0].found_index, result.found_index);
          fails++;
        end
        if (result.result_code !== pending_rsp[0].result_code) begin
          $error("result_code: expected %0d, got %0d",
                 pending_rsp[0].result_code, result.result_code);
          fails++;
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("bitmap_block_allocator_core_tb: errors");
      $finish;
    end
  end

  initial begin
    plan = '{
      '{'{CMD_FIND, MAP_INODE, 12'd0,    1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_FIND, MAP_BLOCK, 12'd0,    1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_INODE, 12'd1023, 1'b1}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_INODE, 12'd1024, 1'b1}, 1'b1, '{12'd0, RC_RANGE}},
      '{'{CMD_SET,  MAP_INODE, 12'd4095, 1'b0}, 1'b1, '{12'd0, RC_RANGE}},
      '{'{CMD_SET,  MAP_INODE, 12'd2048, 1'b1}, 1'b1, '{12'd0, RC_RANGE}},
      '{'{CMD_SET,  MAP_BLOCK, 12'd4095, 1'b1}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_BLOCK, 12'd0,    1'b1}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_FIND, MAP_BLOCK, 12'd0,    1'b0}, 1'b0, '0},
      '{'{CMD_SET,  MAP_INODE, 12'd0,    1'b1}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_INODE, 12'd1,    1'b1}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_FIND, MAP_INODE, 12'd4095, 1'b1}, 1'b0, '0},
      '{'{CMD_SET,  MAP_INODE, 12'd0,    1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_FIND, MAP_INODE, 12'd4095, 1'b0}, 1'b0, '0},
      '{'{CMD_SET,  MAP_BLOCK, 12'd0,    1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_BLOCK, 12'd1,    1'b1}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_FIND, MAP_BLOCK, 12'd2730, 1'b1}, 1'b0, '0},
      '{'{CMD_SET,  MAP_INODE, 12'd1,    1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_INODE, 12'd1023, 1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_BLOCK, 12'd1,    1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_SET,  MAP_BLOCK, 12'd4095, 1'b0}, 1'b1, '{12'd0, RC_OK}},
      '{'{CMD_FIND, MAP_BLOCK, 12'd1365, 1'b0}, 1'b0, '0},
      '{'{CMD_FIND, MAP_INODE, 12'd0,    1'b1}, 1'b0, '0}
    };
    start_lowered = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i].req, plan[i].typed, plan[i].rsp);

    idle_on = 1'b1;
    mix(sent + 350);
    // long stretch with no gaps between requests
    idle_on = 1'b0;
    fill_map(MAP_INODE);
    idle_on = 1'b1;
    mix(sent + 350);

    if (!start_lowered) start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (fails == 0) begin
      $display("bitmap_block_allocator_core_tb: clean");
    end else begin
      $display("bitmap_block_allocator_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bitmap_block_allocator_core.sv
verif/bitmap_block_allocator_core_tb.sv
